/* rtl/core/msrs_pkg.sv */
// Shared types and constants of the multi-stream rate scheduler.
package msrs_pkg;

	// Fixed field widths.
	localparam int TIME_W    = 32;
	localparam int RATE_W    = 16;
	localparam int MASK_W    = 5;
	localparam int CFG_IDX_W = 3;

	// Number of rate registers in the register map.
	localparam int NUM_RATE_REGS = 5;

	// Stream bus widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Reset value of the heartbeat rate register.
	localparam logic [RATE_W-1:0] RATE_RESET_HEARTBEAT = 16'd1;

	// Defaults of the top-level parameters.
	localparam int NUM_STREAMS_DEF      = 5;
	localparam int TICKS_PER_SECOND_DEF = 1000;

	// Operation of the shared adder.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DUE,
		ST_TEST,
		ST_NEXT,
		ST_DIFF,
		ST_MIN,
		ST_OUT
	} state_t;

endpackage

/* rtl/core/multi_stream_rate_scheduler_unit.sv */
// Top level of the multi-stream rate scheduler: sequencer, state and stream ports.
// Per tick the sequencer walks the streams: an enabled stream passes LOAD, DUE, TEST, DIFF
// and MIN, plus NEXT when it is due, plus DIV when its rate was written since its period was last cached.
// A disabled stream passes LOAD only. One tick is processed at a time; a new tick is taken
// only in IDLE, after OUT has handed the last result to the output register.
// Reset: heartbeat rate 1, other rates 0, last send times 0, period cache empty.
module multi_stream_rate_scheduler_unit #(
	parameter int NUM_STREAMS      = msrs_pkg::NUM_STREAMS_DEF,
	parameter int TICKS_PER_SECOND = msrs_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Tick input stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [msrs_pkg::IN_TDATA_W-1:0]      s_tdata,   // [31:0] now_ticks
	// Result stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [msrs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [4:0] due_mask, [36:5] next_delay
	// Rate register writes.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msrs_pkg::RATE_W-1:0]          cfg_data
);
	import msrs_pkg::*;

	// Streams beyond the register map stay disabled, so they are not walked.
	localparam int NUM_REGS = (NUM_STREAMS < NUM_RATE_REGS) ? NUM_STREAMS : NUM_RATE_REGS;
	localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	state_t state_q, state_d;

	logic [RATE_W-1:0] rate_q     [NUM_REGS];
	logic [RATE_W-1:0] period_q   [NUM_REGS];
	logic [TIME_W-1:0] last_q     [NUM_REGS];
	logic [NUM_REGS-1:0] pvalid_q;

	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] due_q;
	logic [TIME_W-1:0] nxt_q;
	logic [TIME_W-1:0] diff_q;
	logic [TIME_W-1:0] best_q;
	logic [MASK_W-1:0] mask_q;
	logic              is_due_q;
	logic              pos_q;

	logic              m_tvalid_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [TIME_W-1:0] out_delay_q;

	logic [TIME_W-1:0] alu_a, alu_b, alu_res;
	alu_op_t           alu_op;
	logic              alu_borrow;

	logic              div_start;
	logic              div_done;
	logic [RATE_W-1:0] div_quo;

	logic              last_idx;
	logic              rate_zero;
	logic              out_free;
	logic              in_xfer;
	logic              cfg_hit;

	assign last_idx  = (idx_q == IDX_W'(NUM_REGS - 1));
	assign rate_zero = (rate_q[idx_q] == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS));

	// Shared adder and divider.
	msrs_alu u_alu (
		.op_a   (alu_a),
		.op_b   (alu_b),
		.op     (alu_op),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	msrs_div #(
		.W (RATE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (RATE_W'(TICKS_PER_SECOND)),
		.divisor  (rate_q[idx_q]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (rate_zero) begin
					state_d = last_idx ? ST_OUT : ST_LOAD;
				end else if (pvalid_q[idx_q]) begin
					state_d = ST_DUE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DUE;
				end
			end
			ST_DUE:  state_d = ST_TEST;
			ST_TEST: state_d = alu_borrow ? ST_DIFF : ST_NEXT;
			ST_NEXT: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MIN;
			ST_MIN:  state_d = last_idx ? ST_OUT : ST_LOAD;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs: handshake, divider start and adder operands.
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		alu_a     = due_q;
		alu_b     = now_q;
		alu_op    = ALU_SUB;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LOAD: div_start = !rate_zero && !pvalid_q[idx_q];
			ST_DUE: begin
				alu_a  = last_q[idx_q];
				alu_b  = TIME_W'(period_q[idx_q]);
				alu_op = ALU_ADD;
			end
			ST_TEST: begin
				alu_a = now_q;
				alu_b = due_q;
			end
			ST_NEXT: begin
				alu_a  = due_q;
				alu_b  = TIME_W'(period_q[idx_q]);
				alu_op = ALU_ADD;
			end
			ST_DIFF: begin
				alu_a = is_due_q ? nxt_q : due_q;
				alu_b = now_q;
			end
			ST_MIN: begin
				alu_a = diff_q;
				alu_b = best_q;
			end
			ST_DIV, ST_OUT: begin
				alu_op = ALU_SUB;
			end
			default: s_tready = 1'b0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Rate registers, period cache and last send times.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				rate_q[i]   <= (i == 0) ? RATE_RESET_HEARTBEAT : '0;
				last_q[i]   <= '0;
				period_q[i] <= '0;
			end
			pvalid_q <= '0;
		end else begin
			if (cfg_hit) begin
				rate_q[cfg_index[IDX_W-1:0]]   <= cfg_data;
				pvalid_q[cfg_index[IDX_W-1:0]] <= 1'b0;
			end
			if (state_q == ST_DIV && div_done) begin
				period_q[idx_q] <= div_quo;
				pvalid_q[idx_q] <= 1'b1;
			end
			if (state_q == ST_TEST && !alu_borrow) begin
				last_q[idx_q] <= now_q;
			end
		end
	end

	// Control state of the walk and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				idx_q <= '0;
			end else if ((state_q == ST_MIN || (state_q == ST_LOAD && rate_zero))
				&& !last_idx) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					now_q  <= s_tdata[TIME_W-1:0];
					best_q <= '1;
					mask_q <= '0;
				end
			end
			ST_DUE: due_q <= alu_res;
			ST_TEST: begin
				is_due_q <= !alu_borrow;
				if (!alu_borrow) begin
					mask_q[idx_q] <= 1'b1;
				end
			end
			ST_NEXT: nxt_q <= alu_res;
			ST_DIFF: begin
				diff_q <= alu_res;
				pos_q  <= !alu_borrow && (alu_res != '0);
			end
			ST_MIN: begin
				// A due stream whose next deadline is not ahead forces a zero delay.
				if (is_due_q && !pos_q) begin
					best_q <= '0;
				end else if (alu_borrow) begin
					best_q <= diff_q;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_mask_q  <= mask_q;
					out_delay_q <= best_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - MASK_W - TIME_W){1'b0}}, out_delay_q, out_mask_q};

endmodule

/* rtl/core/msrs_alu.sv */
// Shared 32-bit add and subtract unit with borrow output.
module msrs_alu (
	input  logic [msrs_pkg::TIME_W-1:0] op_a,
	input  logic [msrs_pkg::TIME_W-1:0] op_b,
	input  msrs_pkg::alu_op_t           op,
	output logic [msrs_pkg::TIME_W-1:0] res,
	output logic                        borrow
);
	import msrs_pkg::*;

	logic [TIME_W:0] sum;

	// One wide adder; the top bit is the borrow of a subtraction.
	always_comb begin
		if (op == ALU_SUB) begin
			sum = {1'b0, op_a} - {1'b0, op_b};
		end else begin
			sum = {1'b0, op_a} + {1'b0, op_b};
		end
	end

	assign res    = sum[TIME_W-1:0];
	assign borrow = sum[TIME_W];

endmodule

/* rtl/core/msrs_div.sv */
// Restoring divider, one quotient bit per cycle, for period computation.
module msrs_div #(
	parameter int W = msrs_pkg::RATE_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	import msrs_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	// Control: count W steps after a start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* tb/multi_stream_rate_scheduler_unit_tb.sv */
// Self-checking testbench for the multi-stream rate scheduler: directed table, random phases.
`timescale 1ns / 1ps

module multi_stream_rate_scheduler_unit_tb;

	localparam int TIME_W   = msrs_pkg::TIME_W;
	localparam int RATE_W   = msrs_pkg::RATE_W;
	localparam int MASK_W   = msrs_pkg::MASK_W;
	localparam int IDX_W    = msrs_pkg::CFG_IDX_W;
	localparam int STREAMS  = msrs_pkg::NUM_STREAMS_DEF;
	localparam logic [TIME_W-1:0] TICK_RATE = msrs_pkg::TICKS_PER_SECOND_DEF;

	// Register map of the rate registers, plus the unmapped part of the index space.
	localparam logic [IDX_W-1:0] REG_HEARTBEAT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_SERVO_OUT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_ATTITUDE    = 3'd2;
	localparam logic [IDX_W-1:0] REG_GPS         = 3'd3;
	localparam logic [IDX_W-1:0] REG_HUD         = 3'd4;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	localparam int PLAN_LEN       = 25;
	localparam int NUM_PHASES     = 10;
	localparam int TICKS_PER_PHASE = 48;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 150;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [MASK_W-1:0] due_mask;
		logic [TIME_W-1:0] next_delay;
	} sched_result_t;

	typedef enum logic {
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [IDX_W-1:0]  reg_idx;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] now;
		logic              typed;
		logic [MASK_W-1:0] mask;
		logic [TIME_W-1:0] delay;
	} plan_row_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [msrs_pkg::IN_TDATA_W-1:0]      s_tdata;   // [31:0] now_ticks
	logic                                 m_tvalid;
	logic                                 m_tready;
	logic [msrs_pkg::OUT_TDATA_W-1:0]     m_tdata;   // [4:0] due_mask, [36:5] next_delay
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [IDX_W-1:0]                     cfg_index;
	logic [RATE_W-1:0]                    cfg_data;

	// Scheduler state as the testbench expects it to be.
	logic [RATE_W-1:0] stream_rate      [STREAMS];
	logic [TIME_W-1:0] stream_last_sent [STREAMS];
	sched_result_t     pending_results  [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;

	plan_row_t plan [PLAN_LEN];

	multi_stream_rate_scheduler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Records a failure; only the first few are reported in detail.
	function automatic void flag_mismatch(input string what, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
		end
	endfunction

	// Works out the due mask and the next delay for one tick and advances the send times.
	function automatic sched_result_t advance_schedule(input logic [TIME_W-1:0] now);
		sched_result_t     res;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] due_at;
		logic [TIME_W-1:0] next_at;
		res.due_mask   = '0;
		res.next_delay = '1;
		for (int s = 0; s < STREAMS; s++) begin
			if (stream_rate[s] != '0) begin
				period = TICK_RATE / {16'd0, stream_rate[s]};
				due_at = stream_last_sent[s] + period;
				if (now >= due_at) begin
					stream_last_sent[s] = now;
					if (s < MASK_W) begin
						res.due_mask[s] = 1'b1;
					end
					next_at = due_at + period;
					if (next_at > now) begin
						if (next_at - now < res.next_delay) begin
							res.next_delay = next_at - now;
						end
					end else begin
						res.next_delay = '0;
					end
				end else if (due_at - now < res.next_delay) begin
					res.next_delay = due_at - now;
				end
			end
		end
		return res;
	endfunction

	// Offers one tick, waits for its transfer and queues what it should produce.
	task automatic drive_tick(input logic [TIME_W-1:0] now, input logic hand_checked,
			input sched_result_t hand_result);
		sched_result_t predicted;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(100, 1) <= send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= now;
		do @(posedge clk); while (!s_tready);
		predicted = advance_schedule(now);
		pending_results.push_back(hand_checked ? hand_result : predicted);
	endtask

	// Lets the block run dry so that a register may be written.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// One register write; writes outside the register map leave the rates alone.
	task automatic write_rate(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < msrs_pkg::NUM_RATE_REGS && idx < STREAMS) begin
			stream_rate[idx] = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) begin
				hold_left = LONG_HOLD;
				hold_seen = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall_pct != 0 && $urandom_range(100, 1) <= recv_stall_pct) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compares every result transfer with the oldest expectation.
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result", '0, m_tdata[TIME_W+MASK_W-1:MASK_W]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[MASK_W-1:0] !== want.due_mask) begin
					flag_mismatch("due_mask", TIME_W'(want.due_mask),
						TIME_W'(m_tdata[MASK_W-1:0]));
				end
				if (m_tdata[TIME_W+MASK_W-1:MASK_W] !== want.next_delay) begin
					flag_mismatch("next_delay", want.next_delay,
						m_tdata[TIME_W+MASK_W-1:MASK_W]);
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases with fresh rates.
	initial begin
		logic [TIME_W-1:0] clock_ms;
		logic [RATE_W-1:0] rate_pick;
		int                guard;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int s = 0; s < STREAMS; s++) begin
			stream_rate[s]      = '0;
			stream_last_sent[s] = '0;
		end
		stream_rate[REG_HEARTBEAT] = msrs_pkg::RATE_RESET_HEARTBEAT;

		// Reset state, wrap of the due time, all streams off, unmapped writes, zero periods.
		plan = '{
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd0,         1'b1, 5'b00000, 32'd1000},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd999,       1'b1, 5'b00000, 32'd1},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd1000,      1'b1, 5'b00001, 32'd1000},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'hFFFF_FFFF, 1'b1, 5'b00001, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd0,         1'b1, 5'b00000, 32'd999},
			'{ROW_WRITE, REG_HEARTBEAT,   16'd0,     32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd12345,     1'b1, 5'b00000, 32'hFFFF_FFFF},
			'{ROW_WRITE, REG_UNMAPPED_LO, 16'd7,     32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_WRITE, REG_UNMAPPED_HI, 16'hFFFF,  32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd0,         1'b1, 5'b00000, 32'hFFFF_FFFF},
			'{ROW_WRITE, REG_SERVO_OUT,   16'hFFFF,  32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd5,         1'b1, 5'b00010, 32'd0},
			'{ROW_WRITE, REG_ATTITUDE,    16'd1000,  32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_WRITE, REG_GPS,         16'd1001,  32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_WRITE, REG_HUD,         16'd1,     32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_WRITE, REG_HEARTBEAT,   16'd1,     32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd100,       1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd101,       1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd101,       1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd1000,      1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'd1999,      1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'h5555_5555, 1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'hAAAA_AAAA, 1'b0, 5'b00000, 32'd0},
			'{ROW_WRITE, REG_SERVO_OUT,   16'd0,     32'd0,         1'b0, 5'b00000, 32'd0},
			'{ROW_TICK,  REG_HEARTBEAT,   16'd0,     32'hAAAA_AAAB, 1'b0, 5'b00000, 32'd0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with no idling on either side.
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].kind == ROW_WRITE) begin
				wait_idle();
				write_rate(plan[r].reg_idx, plan[r].rate);
			end else begin
				drive_tick(plan[r].now, plan[r].typed, '{plan[r].mask, plan[r].delay});
			end
		end

		// Random phases: new rates, a new idling pattern, then a run of ticks.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_idle();
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct  = 18;
					recv_stall_pct = 18;
				end
			endcase
			for (int s = 0; s < STREAMS; s++) begin
				case ($urandom_range(9, 0))
					0:       rate_pick = '0;
					1:       rate_pick = '1;
					2:       rate_pick = RATE_W'($urandom_range(65534, 1001));
					3:       rate_pick = 16'd1;
					default: rate_pick = RATE_W'($urandom_range(1000, 2));
				endcase
				write_rate(IDX_W'(s), rate_pick);
			end
			if (phase % 2 == 1) begin
				write_rate(IDX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
					RATE_W'($urandom));
			end

			// The block fills up while the result side is held off.
			if (phase == 2) begin
				hold_req = 1'b1;
			end

			case ($urandom_range(2, 0))
				0:       clock_ms = $urandom;
				1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(3000, 0);
				default: clock_ms = $urandom_range(3000, 0);
			endcase

			// Mostly a clock that creeps forward; now and then a jump or a step back.
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				case ($urandom_range(19, 0))
					0:       clock_ms = $urandom;
					1:       clock_ms = clock_ms - $urandom_range(500, 1);
					2, 3:    clock_ms = clock_ms + $urandom_range(2000, 0);
					default: clock_ms = clock_ms + $urandom_range(12, 0);
				endcase
				drive_tick(clock_ms, 1'b0, '0);
			end
		end

		// Drain the results, then give the block time to show any stray transfer.
		@(negedge clk);
		s_tvalid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			flag_mismatch("results outstanding", 0, pending_results.size());
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
